[hw/rtl/bilinear_upsample_2x_top_assert.svh]
// Assertion macros for the bilinear 2x upsampler.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BILINEAR_UPSAMPLE_2X_TOP_ASSERT_SVH
`define BILINEAR_UPSAMPLE_2X_TOP_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define BU2X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BU2X_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/bu2x_pkg.sv]
// Shared constants and types of the bilinear 2x upsampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bu2x_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int SampleBits = 16;

  localparam int DimRegW   = 11;
  localparam int PlaneRegW = 16;
  localparam int CoordW    = 11;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPlanes = 2'd2;

  localparam logic [DimRegW-1:0]   WidthReset  = 11'd1024;
  localparam logic [DimRegW-1:0]   HeightReset = 11'd1024;
  localparam logic [PlaneRegW-1:0] PlanesReset = 16'd1;

  typedef struct packed {
    logic row_first;
    logic row_last;
    logic col_first;
    logic col_last;
    logic plane_end;
    logic batch_end;
  } win_flags_t;

endpackage

`default_nettype wire

[hw/rtl/bu2x_ram.sv]
// Generic simple dual-port RAM with registered read, read-first.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bu2x_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/bu2x_ctrl.sv]
// Configuration registers, raster counters, row store access and 2x2 window build.
// Depends on bu2x_pkg; drives the row store RAM instance in the top level.
`timescale 1ns / 1ps
`default_nettype none

module bu2x_ctrl #(
  parameter int MAX_WIDTH   = bu2x_pkg::MaxWidth,
  parameter int MAX_HEIGHT  = bu2x_pkg::MaxHeight,
  parameter int SAMPLE_BITS = bu2x_pkg::SampleBits
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bu2x_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [bu2x_pkg::CfgDataW-1:0]       cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_pixel_i,
  output logic                                     ram_we_o,
  output logic                                     ram_re_o,
  output logic      [$clog2(MAX_WIDTH)-1:0]        ram_addr_o,
  output logic      [SAMPLE_BITS-1:0]              ram_wdata_o,
  input  wire logic [SAMPLE_BITS-1:0]              ram_rdata_i,
  output logic                                     win_valid_o,
  input  wire logic                                win_ready_i,
  output logic signed [SAMPLE_BITS-1:0]            win_b00_o,
  output logic signed [SAMPLE_BITS-1:0]            win_b01_o,
  output logic signed [SAMPLE_BITS-1:0]            win_b10_o,
  output logic signed [SAMPLE_BITS-1:0]            win_b11_o,
  output logic      [$clog2(MAX_HEIGHT)-1:0]       win_row_o,
  output logic      [$clog2(MAX_WIDTH)-1:0]        win_col_o,
  output bu2x_pkg::win_flags_t                     win_flags_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = bu2x_pkg::PlaneRegW;

  logic [bu2x_pkg::DimRegW-1:0] width_q;
  logic [bu2x_pkg::DimRegW-1:0] height_q;
  logic [PW-1:0]                planes_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] plane_q, plane_d;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [PW-1:0] pc_eff;

  logic          col_over, row_over;
  logic [CW-1:0] c_eff;
  logic [RW:0]   r_pre;
  logic [RW-1:0] r_eff;
  logic [PW:0]   p_pre;
  logic [PW-1:0] p_eff;
  logic [CW:0]   c_nxt;
  logic [RW:0]   r_nxt;
  logic [PW:0]   p_nxt;
  logic          col_wrap, row_wrap, plane_wrap;

  logic                 accept;
  bu2x_pkg::win_flags_t flags_d;

  logic                          pix_valid_q;
  logic signed [SAMPLE_BITS-1:0] pix_cur_q;
  logic [RW-1:0]                 pix_row_q;
  logic [CW-1:0]                 pix_col_q;
  bu2x_pkg::win_flags_t          pix_flags_q;
  logic signed [SAMPLE_BITS-1:0] left_cur_q, left_above_q;
  logic signed [SAMPLE_BITS-1:0] stored;
  logic                          pix_take;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(32'(width_q));
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(32'(height_q));
    end
    pc_eff = (planes_q == '0) ? PW'(1) : planes_q;
  end

  always_comb begin
    col_over = 32'(col_q) >= 32'(w_eff);
    c_eff    = col_over ? '0 : col_q;
    r_pre    = (RW+1)'(row_q) + (RW+1)'(col_over);
    row_over = 32'(r_pre) >= 32'(h_eff);
    r_eff    = row_over ? '0 : RW'(r_pre);
    p_pre    = (PW+1)'(plane_q) + (PW+1)'(row_over);
    p_eff    = (32'(p_pre) >= 32'(pc_eff)) ? '0 : PW'(p_pre);

    c_nxt      = (CW+1)'(c_eff) + (CW+1)'(1);
    r_nxt      = (RW+1)'(r_eff) + (RW+1)'(1);
    p_nxt      = (PW+1)'(p_eff) + (PW+1)'(1);
    col_wrap   = 32'(c_nxt) >= 32'(w_eff);
    row_wrap   = col_wrap && (32'(r_nxt) >= 32'(h_eff));
    plane_wrap = 32'(p_nxt) >= 32'(pc_eff);

    col_d   = col_wrap ? '0 : CW'(c_nxt);
    row_d   = col_wrap ? (row_wrap ? '0 : RW'(r_nxt)) : r_eff;
    plane_d = row_wrap ? (plane_wrap ? '0 : PW'(p_nxt)) : p_eff;

    flags_d.row_first = r_eff == '0;
    flags_d.row_last  = 32'(r_eff) == 32'(h_eff) - 32'd1;
    flags_d.col_first = c_eff == '0;
    flags_d.col_last  = 32'(c_eff) == 32'(w_eff) - 32'd1;
    flags_d.plane_end = flags_d.row_last && flags_d.col_last;
    flags_d.batch_end = flags_d.plane_end && (32'(p_eff) == 32'(pc_eff) - 32'd1);
  end

  assign pix_take   = pix_valid_q && win_ready_i;
  assign in_ready_o = !pix_valid_q || win_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The row store is read and overwritten at the same column; the read returns the old row.
  assign ram_we_o    = accept;
  assign ram_re_o    = accept;
  assign ram_addr_o  = c_eff;
  assign ram_wdata_o = in_pixel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= bu2x_pkg::WidthReset;
      height_q     <= bu2x_pkg::HeightReset;
      planes_q     <= bu2x_pkg::PlanesReset;
      col_q        <= '0;
      row_q        <= '0;
      plane_q      <= '0;
      pix_valid_q  <= 1'b0;
      left_cur_q   <= '0;
      left_above_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bu2x_pkg::CfgWidth:  width_q  <= cfg_data_i[bu2x_pkg::DimRegW-1:0];
          bu2x_pkg::CfgHeight: height_q <= cfg_data_i[bu2x_pkg::DimRegW-1:0];
          bu2x_pkg::CfgPlanes: planes_q <= cfg_data_i[PW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        plane_q <= plane_d;
      end
      if (accept) begin
        pix_valid_q <= 1'b1;
      end else if (pix_take) begin
        pix_valid_q <= 1'b0;
      end
      if (pix_take) begin
        left_cur_q   <= pix_cur_q;
        left_above_q <= stored;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_cur_q   <= in_pixel_i;
      pix_row_q   <= r_eff;
      pix_col_q   <= c_eff;
      pix_flags_q <= flags_d;
    end
  end

  always_comb begin
    stored    = $signed(ram_rdata_i);
    win_b11_o = pix_cur_q;
    win_b10_o = pix_flags_q.col_first ? pix_cur_q : left_cur_q;
    win_b01_o = pix_flags_q.row_first ? pix_cur_q : stored;
    if (pix_flags_q.col_first) begin
      win_b00_o = win_b01_o;
    end else if (pix_flags_q.row_first) begin
      win_b00_o = win_b10_o;
    end else begin
      win_b00_o = left_above_q;
    end
  end

  assign win_valid_o = pix_valid_q;
  assign win_row_o   = pix_row_q;
  assign win_col_o   = pix_col_q;
  assign win_flags_o = pix_flags_q;

endmodule

`default_nettype wire

[hw/rtl/bu2x_emit.sv]
// Result sequencer: walks the output taps of one window, weights and rounds, output register.
// Depends on bu2x_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bu2x_emit #(
  parameter int MAX_WIDTH   = bu2x_pkg::MaxWidth,
  parameter int MAX_HEIGHT  = bu2x_pkg::MaxHeight,
  parameter int SAMPLE_BITS = bu2x_pkg::SampleBits
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                win_valid_i,
  output logic                                     win_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       win_b00_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       win_b01_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       win_b10_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       win_b11_i,
  input  wire logic      [$clog2(MAX_HEIGHT)-1:0]  win_row_i,
  input  wire logic      [$clog2(MAX_WIDTH)-1:0]   win_col_i,
  input  wire bu2x_pkg::win_flags_t                win_flags_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [bu2x_pkg::CoordW-1:0]              out_row_o,
  output logic [bu2x_pkg::CoordW-1:0]              out_col_o,
  output logic signed [SAMPLE_BITS-1:0]            out_value_o,
  output logic                                     out_last_o,
  output logic                                     out_plane_o,
  output logic                                     out_batch_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = SAMPLE_BITS + 6;

  // Prev: position 2i-1, weights 3:1. Mid: 2i, weights 1:3. Edge: 2i+1, weights 0:4.
  typedef enum logic [1:0] {
    TapPrev,
    TapMid,
    TapEdge
  } tap_e;

  function automatic logic signed [SW-1:0] wsum(input logic signed [SW-1:0] p,
                                               input logic signed [SW-1:0] c,
                                               input tap_e t);
    logic signed [SW-1:0] s;
    case (t)
      TapPrev: s = (p <<< 1) + p + c;
      TapMid:  s = p + (c <<< 1) + c;
      TapEdge: s = c <<< 2;
      default: s = '0;
    endcase
    return s;
  endfunction

  logic                          e_valid_q;
  tap_e                          e_ra_q, e_rend_q, e_ca_q, e_cstart_q, e_cend_q;
  logic signed [SAMPLE_BITS-1:0] e_b00_q, e_b01_q, e_b10_q, e_b11_q;
  logic [RW-1:0]                 e_row_q;
  logic [CW-1:0]                 e_col_q;
  logic                          e_plane_q, e_batch_q;

  logic                 e_last, emit, load;
  logic signed [SW-1:0] top, bot, sum, rnd;
  logic [RW+1:0]        row_pos;
  logic [CW+1:0]        col_pos;

  logic                          out_valid_q;
  logic [bu2x_pkg::CoordW-1:0]   out_row_q, out_col_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic                          out_last_q, out_plane_q, out_batch_q;

  assign e_last      = (e_ra_q == e_rend_q) && (e_ca_q == e_cend_q);
  assign emit        = e_valid_q && (!out_valid_q || out_ready_i);
  assign win_ready_o = !e_valid_q || (emit && e_last);
  assign load        = win_valid_i && win_ready_o;

  always_comb begin
    top = wsum({{6{e_b00_q[SAMPLE_BITS-1]}}, e_b00_q},
               {{6{e_b01_q[SAMPLE_BITS-1]}}, e_b01_q}, e_ca_q);
    bot = wsum({{6{e_b10_q[SAMPLE_BITS-1]}}, e_b10_q},
               {{6{e_b11_q[SAMPLE_BITS-1]}}, e_b11_q}, e_ca_q);
    sum = wsum(top, bot, e_ra_q);
    rnd = sum + SW'(8);
    row_pos = (RW+2)'({e_row_q, 1'b0}) + (RW+2)'(e_ra_q) - (RW+2)'(1);
    col_pos = (CW+2)'({e_col_q, 1'b0}) + (CW+2)'(e_ca_q) - (CW+2)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      e_ra_q      <= TapMid;
      e_rend_q    <= TapMid;
      e_ca_q      <= TapMid;
      e_cstart_q  <= TapMid;
      e_cend_q    <= TapMid;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        e_valid_q  <= 1'b1;
        e_ra_q     <= win_flags_i.row_first ? TapMid : TapPrev;
        e_rend_q   <= win_flags_i.row_last ? TapEdge : TapMid;
        e_ca_q     <= win_flags_i.col_first ? TapMid : TapPrev;
        e_cstart_q <= win_flags_i.col_first ? TapMid : TapPrev;
        e_cend_q   <= win_flags_i.col_last ? TapEdge : TapMid;
      end else if (emit) begin
        if (e_last) begin
          e_valid_q <= 1'b0;
        end else if (e_ca_q == e_cend_q) begin
          e_ca_q <= e_cstart_q;
          e_ra_q <= tap_e'(e_ra_q + 2'd1);
        end else begin
          e_ca_q <= tap_e'(e_ca_q + 2'd1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      e_b00_q   <= win_b00_i;
      e_b01_q   <= win_b01_i;
      e_b10_q   <= win_b10_i;
      e_b11_q   <= win_b11_i;
      e_row_q   <= win_row_i;
      e_col_q   <= win_col_i;
      e_plane_q <= win_flags_i.plane_end;
      e_batch_q <= win_flags_i.batch_end;
    end
    if (emit) begin
      out_row_q   <= bu2x_pkg::CoordW'(32'(row_pos));
      out_col_q   <= bu2x_pkg::CoordW'(32'(col_pos));
      out_value_q <= rnd[SAMPLE_BITS+3:4];
      out_last_q  <= e_last;
      out_plane_q <= e_last && e_plane_q;
      out_batch_q <= e_last && e_batch_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_plane_o = out_plane_q;
  assign out_batch_o = out_batch_q;

endmodule

`default_nettype wire

[hw/rtl/bilinear_upsample_2x_top.sv]
// Bilinear 2x upsampler with half-pixel centers and clamped borders.
// Input pixels of a plane enter in raster order on the slave stream. Each word releases
// the one to nine output pixels it completes, ordered by row then column, on the master
// stream with their coordinates; tlast marks the last result of each input word.
// The user must write registers (width, height, plane count) through the cfg port only
// while idle; the block does not enforce this. A word passes the window, sequencer and
// output registers before its first result is valid. Throughput: one result per cycle from
// the result sequencer while the receiver takes them, one for each row and column tap pair
// a word finishes; a new word is taken as soon as the sequencer starts on its last result.
// The previous input row sits in a single-port-per-side RAM read and rewritten at the same
// column when a word is accepted; the read returns the old row.
// Reset clears counters, valid flags and registers to width 1024, height 1024, one plane.
// The row store needs no clearing: its contents are never used for the first row of a plane.
// When the receiver stalls, the output register holds, the sequencer and window stage
// fill, and s_axis_tready drops.
// Depends on bu2x_pkg, bu2x_ram, bu2x_ctrl, bu2x_emit and bilinear_upsample_2x_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "bilinear_upsample_2x_top_assert.svh"

module bilinear_upsample_2x_top #(
  parameter int MAX_WIDTH   = bu2x_pkg::MaxWidth,
  parameter int MAX_HEIGHT  = bu2x_pkg::MaxHeight,
  parameter int SAMPLE_BITS = bu2x_pkg::SampleBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bu2x_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [bu2x_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // pixel_value
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_row, out_col, out_value
  output logic [((2*bu2x_pkg::CoordW+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                                    m_axis_tlast,
  // end_of_plane, end_of_batch
  output logic [1:0]                              m_axis_tuser
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(MAX_HEIGHT);
  localparam int OutDataW = ((2*bu2x_pkg::CoordW+SAMPLE_BITS+7)/8)*8;

  logic                          ram_we, ram_re;
  logic [CW-1:0]                 ram_addr;
  logic [SAMPLE_BITS-1:0]        ram_wdata, ram_rdata;
  logic                          win_valid, win_ready;
  logic signed [SAMPLE_BITS-1:0] win_b00, win_b01, win_b10, win_b11;
  logic [RW-1:0]                 win_row;
  logic [CW-1:0]                 win_col;
  bu2x_pkg::win_flags_t          win_flags;
  logic [bu2x_pkg::CoordW-1:0]   out_row, out_col;
  logic signed [SAMPLE_BITS-1:0] out_value;
  logic                          out_plane, out_batch;

  bu2x_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pixel_i  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_b00_o   (win_b00),
    .win_b01_o   (win_b01),
    .win_b10_o   (win_b10),
    .win_b11_o   (win_b11),
    .win_row_o   (win_row),
    .win_col_o   (win_col),
    .win_flags_o (win_flags)
  );

  bu2x_ram #(
    .Width (SAMPLE_BITS),
    .Depth (MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  bu2x_emit #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_b00_i   (win_b00),
    .win_b01_i   (win_b01),
    .win_b10_i   (win_b10),
    .win_b11_i   (win_b11),
    .win_row_i   (win_row),
    .win_col_i   (win_col),
    .win_flags_i (win_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_plane_o (out_plane),
    .out_batch_o (out_batch)
  );

  assign m_axis_tdata = OutDataW'({out_value, out_col, out_row});
  assign m_axis_tuser = {out_batch, out_plane};

  `BU2X_ASSERT(a_accept_fills_window, (s_axis_tvalid && s_axis_tready) |=> win_valid, "accepted word did not reach the window stage")
  `BU2X_NEVER(a_write_without_accept, ram_we && !(s_axis_tvalid && s_axis_tready), "row store written without an accepted word")
  `BU2X_NEVER(a_plane_end_not_last, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast, "end of plane on a result that is not last of its word")
  `BU2X_NEVER(a_batch_without_plane, m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0], "end of batch without end of plane")

endmodule

`default_nettype wire

[test/bu2x_upsample_checker.sv]
// Checker for bilinear_upsample_2x_top: follows register writes, predicts the output pixels
// of every accepted input word and compares them in order with the master stream.
// Depends on bu2x_pkg.
`timescale 1ns / 1ps

module bu2x_upsample_checker #(
  parameter int IN_W  = ((bu2x_pkg::SampleBits + 7) / 8) * 8,
  parameter int OUT_W = ((2 * bu2x_pkg::CoordW + bu2x_pkg::SampleBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bu2x_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bu2x_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [IN_W-1:0]                  s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [OUT_W-1:0]                 m_tdata_i,
  input  logic                             m_tlast_i,
  input  logic [1:0]                       m_tuser_i,
  output int                               pending_o,
  output int                               fail_count_o
);
  import bu2x_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0]            row;
    logic [CoordW-1:0]            col;
    logic signed [SampleBits-1:0] value;
    logic                         last_run;
    logic                         plane_end;
    logic                         batch_end;
  } out_px_t;

  typedef struct packed {
    logic [1:0]              n;
    logic [2:0][CoordW-1:0]  pos;
    logic [2:0][2:0]         w_prev;
    logic [2:0][2:0]         w_cur;
  } taps_t;

  out_px_t                      expected_px[$];
  logic signed [SampleBits-1:0] prev_row [MaxWidth];
  logic signed [SampleBits-1:0] left_cur;
  logic signed [SampleBits-1:0] left_above;
  int unsigned                  row_cnt;
  int unsigned                  col_cnt;
  int unsigned                  plane_cnt;
  logic [DimRegW-1:0]           reg_width;
  logic [DimRegW-1:0]           reg_height;
  logic [PlaneRegW-1:0]         reg_planes;
  int                           fails = 0;

  // Output lines along one axis finished by input line idx, with the weights (of four)
  // of the earlier and the current input line.
  function automatic taps_t axis_taps(input int unsigned idx, input int unsigned len);
    taps_t t;
    t = '0;
    if (idx >= 1) begin
      t.pos[t.n] = CoordW'(2 * idx - 1);
      t.w_prev[t.n] = 3'd3;
      t.w_cur[t.n] = 3'd1;
      t.n = t.n + 2'd1;
    end
    t.pos[t.n] = CoordW'(2 * idx);
    t.w_prev[t.n] = 3'd1;
    t.w_cur[t.n] = 3'd3;
    t.n = t.n + 2'd1;
    if (idx == len - 1) begin
      t.pos[t.n] = CoordW'(2 * idx + 1);
      t.w_prev[t.n] = 3'd0;
      t.w_cur[t.n] = 3'd4;
      t.n = t.n + 2'd1;
    end
    return t;
  endfunction

  task automatic predict_outputs(input logic signed [SampleBits-1:0] px);
    int unsigned w, h, pc, r, c;
    int cur, stored, b00, b01, b10, b11, top, bot, sum, wpr, wcr, wpc, wcc;
    logic plane_end, batch_end;
    taps_t rt, ct;
    out_px_t o;
    w  = (reg_width == 0) ? 1 : ((reg_width > MaxWidth) ? MaxWidth : reg_width);
    h  = (reg_height == 0) ? 1 : ((reg_height > MaxHeight) ? MaxHeight : reg_height);
    pc = (reg_planes == 0) ? 1 : reg_planes;
    // Counters left past the current limits by a register change wrap first.
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) begin
      row_cnt = 0;
      plane_cnt++;
    end
    if (plane_cnt >= pc) plane_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    cur    = px;
    stored = prev_row[c];
    b11 = cur;
    b10 = (c == 0) ? cur : left_cur;
    b01 = (r == 0) ? cur : stored;
    if (c == 0) b00 = b01;
    else if (r == 0) b00 = b10;
    else b00 = left_above;
    rt = axis_taps(r, h);
    ct = axis_taps(c, w);
    plane_end = (r == h - 1) && (c == w - 1);
    batch_end = plane_end && (plane_cnt == pc - 1);
    for (int a = 0; a < rt.n; a++) begin
      for (int b = 0; b < ct.n; b++) begin
        wpr = rt.w_prev[a];
        wcr = rt.w_cur[a];
        wpc = ct.w_prev[b];
        wcc = ct.w_cur[b];
        top = wpc * b00 + wcc * b01;
        bot = wpc * b10 + wcc * b11;
        sum = wpr * top + wcr * bot;
        o.row       = rt.pos[a];
        o.col       = ct.pos[b];
        o.value     = SampleBits'((sum + 8) >>> 4);
        o.last_run  = (a == rt.n - 1) && (b == ct.n - 1);
        o.plane_end = o.last_run && plane_end;
        o.batch_end = o.last_run && batch_end;
        expected_px.push_back(o);
      end
    end
    left_above  = stored;
    left_cur    = px;
    prev_row[c] = px;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) begin
        row_cnt = 0;
        plane_cnt++;
        if (plane_cnt >= pc) plane_cnt = 0;
      end
    end
  endtask

  task automatic compare_output();
    out_px_t got, exp_px;
    got.row       = m_tdata_i[CoordW-1:0];
    got.col       = m_tdata_i[2*CoordW-1:CoordW];
    got.value     = m_tdata_i[2*CoordW+SampleBits-1:2*CoordW];
    got.last_run  = m_tlast_i;
    got.plane_end = m_tuser_i[0];
    got.batch_end = m_tuser_i[1];
    if (expected_px.size() == 0) begin
      fails++;
      $display("%0t: mismatch, expected no word, got row %0d col %0d value %0d", $time,
               got.row, got.col, got.value);
    end else begin
      exp_px = expected_px.pop_front();
      if (got.row !== exp_px.row || got.col !== exp_px.col ||
          got.value !== exp_px.value || got.last_run !== exp_px.last_run ||
          got.plane_end !== exp_px.plane_end || got.batch_end !== exp_px.batch_end) begin
        fails++;
        $display({"%0t: mismatch, expected row %0d col %0d value %0d last %b plane %b ",
                  "batch %b, got row %0d col %0d value %0d last %b plane %b batch %b"},
                 $time, exp_px.row, exp_px.col, exp_px.value, exp_px.last_run,
                 exp_px.plane_end, exp_px.batch_end, got.row, got.col, got.value,
                 got.last_run, got.plane_end, got.batch_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_width  = WidthReset;
      reg_height = HeightReset;
      reg_planes = PlanesReset;
      left_cur   = '0;
      left_above = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      plane_cnt  = 0;
      expected_px.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWidth:  reg_width  = cfg_data_i[DimRegW-1:0];
          CfgHeight: reg_height = cfg_data_i[DimRegW-1:0];
          CfgPlanes: reg_planes = cfg_data_i[PlaneRegW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) predict_outputs(s_tdata_i[SampleBits-1:0]);
      if (m_tvalid_i && m_tready_i) compare_output();
    end
    pending_o    = expected_px.size();
    fail_count_o = fails;
  end

endmodule

[test/bilinear_upsample_2x_top_tb.sv]
// Testbench top for bilinear_upsample_2x_top: writes registers and streams pixel words
// under several idle and stall patterns, then gives the verdict.
// Depends on bu2x_pkg, the block's RTL and bu2x_upsample_checker.
`timescale 1ns / 1ps

module bilinear_upsample_2x_top_tb;
  import bu2x_pkg::*;

  localparam int InDataW     = ((SampleBits + 7) / 8) * 8;
  localparam int OutDataW    = ((2 * CoordW + SampleBits + 7) / 8) * 8;
  localparam int RandomWords = 200;
  localparam int WideWords   = 128;
  localparam int TallWords   = 64;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 1_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;
  int                   pending;
  int                   fail_count;

  logic                 hold_req = 1'b0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   cycles = 0;
  int                   words_sent = 0;
  int                   reg_writes = 0;
  int                   phases = 0;
  int unsigned          eff_w = 1024;
  int unsigned          eff_h = 1024;
  int unsigned          pos_row = 0;
  int unsigned          pos_col = 0;

  bilinear_upsample_2x_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  bu2x_upsample_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int unsigned clamp_dim(input logic [DimRegW-1:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      3: return '1;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  task automatic set_pace(input int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 81; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 81; end
      default: begin send_idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  // Applies the wrap that the block does before a word when the limits moved.
  task automatic settle_pos();
    if (pos_col >= eff_w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= eff_h) pos_row = 0;
  endtask

  function automatic int words_to_plane_end();
    return (eff_h - pos_row) * eff_w - pos_col;
  endfunction

  // Called right after a rising edge; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    reg_writes++;
    if (idx == CfgWidth) eff_w = clamp_dim(data[DimRegW-1:0]);
    else if (idx == CfgHeight) eff_h = clamp_dim(data[DimRegW-1:0]);
  endtask

  task automatic send_word(input logic [SampleBits-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(px);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    settle_pos();
    pos_col++;
    if (pos_col >= eff_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= eff_h) pos_row = 0;
    end
  endtask

  task automatic send_words(input int n);
    repeat (n) send_word(pick_sample());
  endtask

  // Lowers valid, then waits until every predicted result has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  logic [SampleBits-1:0] corner_px [12] = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                            16'h0000, 16'hffff, 16'h8000, 16'h7fff,
                                            16'h0001, 16'hfffe, 16'h8000, 16'h7fff};
  int n, rand_start;
  logic at_start;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-pixel plane; a plane count of zero acts as one.
    write_reg(CfgWidth, 16'd1);
    write_reg(CfgHeight, 16'd1);
    write_reg(CfgPlanes, 16'd0);
    cfg_we_i <= 1'b0;
    send_word(16'h7fff);
    send_word(16'h8000);

    // Two small planes of full-scale and near-zero values.
    wait_idle();
    write_reg(CfgWidth, 16'd3);
    write_reg(CfgHeight, 16'd2);
    write_reg(CfgPlanes, 16'd2);
    cfg_we_i <= 1'b0;
    foreach (corner_px[i]) send_word(corner_px[i]);

    // Height and plane count lowered in the middle of a plane.
    wait_idle();
    write_reg(CfgWidth, 16'd4);
    write_reg(CfgHeight, 16'd4);
    write_reg(CfgPlanes, 16'd3);
    cfg_we_i <= 1'b0;
    send_words(6);
    wait_idle();
    write_reg(CfgHeight, 16'd1);
    write_reg(CfgPlanes, 16'd1);
    cfg_we_i <= 1'b0;
    settle_pos();
    send_words(words_to_plane_end());

    // Start of the widest row, clamped from 2047, with a long receiver hold-off.
    wait_idle();
    write_reg(CfgWidth, 16'd2047);
    write_reg(CfgHeight, 16'd0);
    write_reg(CfgPlanes, 16'd1);
    cfg_we_i <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    send_words(WideWords);

    // Width dropped to one pixel mid-row, going on down the tallest plane size in a
    // batch of the largest plane count.
    wait_idle();
    set_pace(2);
    write_reg(CfgWidth, 16'd1);
    write_reg(CfgHeight, 16'd2047);
    write_reg(CfgPlanes, 16'hffff);
    cfg_we_i <= 1'b0;
    send_words(TallWords);

    rand_start = words_sent;
    while (words_sent - rand_start < RandomWords) begin
      wait_idle();
      set_pace(phases);
      phases++;
      settle_pos();
      at_start = (pos_row == 0) && (pos_col == 0);
      if (at_start) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
        write_reg(CfgWidth, {5'($urandom), 11'(n)});
        write_reg(CfgHeight, {5'($urandom), 11'($urandom_range(0, 6))});
        write_reg(CfgPlanes, 16'($urandom_range(0, 4)));
      end else begin
        case ($urandom_range(2))
          0: write_reg(CfgHeight, 16'($urandom_range(0, 6)));
          1: write_reg(CfgWidth, 16'($urandom_range(0, eff_w)));
          default: write_reg(CfgPlanes, 16'($urandom_range(0, 4)));
        endcase
      end
      cfg_we_i <= 1'b0;
      settle_pos();
      n = words_to_plane_end();
      if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      else if (eff_w * eff_h <= 36) n += eff_w * eff_h * $urandom_range(0, 2);
      if (n > RandomWords - (words_sent - rand_start))
        n = RandomWords - (words_sent - rand_start);
      send_words(n);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d pixel words over %0d register writes, including clamped sizes,",
             words_sent, reg_writes);
    $display("mid-plane changes, %0d random phases and one long receiver hold-off.", phases);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
